### design/stable_max_priority_queue_defines.svh
// Assertion macros for the priority queue.
// Each use expands to one labelled concurrent assertion, or to nothing in synthesis.
`ifndef STABLE_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_MAX_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// overlapping implication
`define SMPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smpq: assertion failed");
// non-overlapping implication, consequent checked in the next cycle
`define SMPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smpq: assertion failed");
`else
`define SMPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define SMPQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/smpq_pkg.sv
`default_nettype none

package smpq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int TAG_BITS      = 16;
   localparam int IDX_W         = $clog2(QUEUE_DEPTH);
   localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W       = PRIORITY_BITS + TAG_BITS;

   // stream field widths
   localparam int FIELD_W     = 16;
   localparam int OCC_W       = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   // request kinds
   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_CONSUME = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } smpq_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_CONS,
      ST_RESP
   } smpq_state_type;

endpackage

`default_nettype wire

### design/stable_max_priority_queue.sv
`default_nettype none
`include "stable_max_priority_queue_defines.svh"
// Stable max-priority queue of request tags, up to QUEUE_DEPTH entries.
// req channel: tuser selects insert (0) or consume (1); tdata carries tag and priority.
// rsp channel: one transfer per request with status, the consumed entry and occupancy.
// Entries live in one synchronous RAM as a circular list sorted head-first, with
// equal priorities kept in arrival order.
// Consume: one read at the head pointer; the entry goes from the RAM read register
// into the result registers in ST_CONS, then to the output register from ST_RESP.
// Insert: walks back from the tail in ST_SCAN, one entry per cycle moved up by one
// slot, then writes the new entry in ST_PLACE; an insert into an empty queue goes
// straight to ST_PLACE. The single RAM read port paces the walk.
// Dropped inserts (full) and empty consumes go straight to ST_RESP.
// One request is in work at a time; req_tready is high only when the engine is idle,
// so the next request transfer comes at the earliest in the cycle after the result
// is loaded into the output register.
// The next request is taken while a result still waits in the output register.
// A stalled rsp side holds the result; a finished request then waits for the
// output register before the engine goes idle.
// Reset empties the queue at once (count and head pointer cleared, RAM untouched).
module stable_max_priority_queue
   import smpq_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire                     req_tuser,   // [0] mode
   input  wire  [REQ_TDATA_W-1:0]  req_tdata,   // [15:0] request_tag, [31:16] priority_req
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [RSP_TUSER_W-1:0]  rsp_tuser,   // [1:0] status, [2] out_valid
   output logic [RSP_TDATA_W-1:0]  rsp_tdata    // [15:0] out_tag, [31:16] out_priority,
                                                // [36:32] occupancy, [39:37] zero
);

   smpq_state_type state_ff, state_in;

   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         vac_ff, vac_in;
   logic [PRIORITY_BITS-1:0] new_prio_ff, new_prio_in;
   logic [TAG_BITS-1:0]      new_tag_ff, new_tag_in;

   smpq_status_type          res_status_ff, res_status_in;
   logic                     res_valid_ff, res_valid_in;
   logic [TAG_BITS-1:0]      res_tag_ff, res_tag_in;
   logic [PRIORITY_BITS-1:0] res_prio_ff, res_prio_in;

   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   smpq_status_type          rsp_status_ff, rsp_status_in;
   logic                     rsp_oval_ff, rsp_oval_in;
   logic [TAG_BITS-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [PRIORITY_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [CNT_W-1:0]         rsp_occ_ff, rsp_occ_in;

   // RAM ports
   logic [ENTRY_W-1:0] slot_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_en, wr_en;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic                     req_fire;
   logic                     rsp_free;
   logic                     req_mode;
   logic [TAG_BITS-1:0]      req_tag;
   logic [PRIORITY_BITS-1:0] req_prio;
   logic [PRIORITY_BITS-1:0] rd_prio;
   logic [TAG_BITS-1:0]      rd_tag;
   logic                     scan_move;
   logic                     scan_last;
   logic                     is_full;
   logic                     is_empty;

   // list position to RAM address, wrapping round the circular buffer
   function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + (IDX_W+1)'(offs);
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_mode   = req_tuser;
   assign req_tag    = TAG_BITS'(req_tdata[FIELD_W-1:0]);
   assign req_prio   = PRIORITY_BITS'(req_tdata[2*FIELD_W-1:FIELD_W]);
   assign rd_prio    = rd_data_ff[ENTRY_W-1 -: PRIORITY_BITS];
   assign rd_tag     = rd_data_ff[TAG_BITS-1:0];
   assign is_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty   = (count_ff == '0);
   // stored entry is lower: move it up one slot and keep walking
   assign scan_move  = (rd_prio < new_prio_ff);
   assign scan_last  = (vac_ff == CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_INSERT) begin
                  if (is_full) begin
                     state_in = ST_RESP;
                  end else if (is_empty) begin
                     state_in = ST_PLACE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  state_in = is_empty ? ST_RESP : ST_CONS;
               end
            end
         end
         ST_SCAN: begin
            if (!scan_move || scan_last) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_RESP;
         ST_CONS:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_addr(head_ff, vac_ff);
      wr_data       = {new_prio_ff, new_tag_ff};
      head_in       = head_ff;
      count_in      = count_ff;
      vac_in        = vac_ff;
      new_prio_in   = new_prio_ff;
      new_tag_in    = new_tag_ff;
      res_status_in = res_status_ff;
      res_valid_in  = res_valid_ff;
      res_tag_in    = res_tag_ff;
      res_prio_in   = res_prio_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_oval_in   = rsp_oval_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               new_tag_in    = req_tag;
               new_prio_in   = req_prio;
               res_status_in = STATUS_OK;
               res_valid_in  = 1'b0;
               res_tag_in    = '0;
               res_prio_in   = '0;
               if (req_mode == MODE_INSERT) begin
                  if (is_full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     // start the walk at the tail; empty list goes straight to the head
                     vac_in  = count_ff;
                     rd_en   = !is_empty;
                     rd_addr = slot_addr(head_ff, count_ff - CNT_W'(1));
                  end
               end else begin
                  if (is_empty) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     head_in  = slot_addr(head_ff, CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_move) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               vac_in  = vac_ff - CNT_W'(1);
               if (!scan_last) begin
                  rd_en   = 1'b1;
                  rd_addr = slot_addr(head_ff, vac_ff - CNT_W'(2));
               end
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         ST_CONS: begin
            res_valid_in = 1'b1;
            res_tag_in   = rd_tag;
            res_prio_in  = rd_prio;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_oval_in   = res_valid_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_prio_in   = res_prio_ff;
               rsp_occ_in    = count_ff;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      vac_ff        <= vac_in;
      new_prio_ff   <= new_prio_in;
      new_tag_ff    <= new_tag_in;
      res_status_ff <= res_status_in;
      res_valid_ff  <= res_valid_in;
      res_tag_ff    <= res_tag_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_oval_ff   <= rsp_oval_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // slot RAM, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // output packing
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = {rsp_oval_ff, rsp_status_ff};
   assign rsp_tdata  = {(RSP_TDATA_W - 2*FIELD_W - OCC_W)'(0),
                        OCC_W'(rsp_occ_ff),
                        FIELD_W'(rsp_prio_ff),
                        FIELD_W'(rsp_tag_ff)};

   // checks
   `SMPQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SMPQ_ASSERT_NXT(a_accept_busy, clock, reset, req_fire, state_ff != ST_IDLE)
   `SMPQ_ASSERT_IMP(a_scan_vacancy, clock, reset, state_ff == ST_SCAN, vac_ff != '0)
   `SMPQ_ASSERT_IMP(a_port_apart, clock, reset, wr_en && rd_en, wr_addr != rd_addr)
   `SMPQ_ASSERT_NXT(a_place_grows, clock, reset, state_ff == ST_PLACE,
                    count_ff == $past(count_ff) + CNT_W'(1))

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import smpq_pkg::*;

   localparam int ITEM_COUNT   = 1200;
   localparam int CALM_TAIL    = 150;     // last requests run with no idling
   localparam int HOLD_AFTER   = 200;     // results seen before the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic                     mode;
      logic [TAG_BITS-1:0]      tag;
      logic [PRIORITY_BITS-1:0] prio;
   } queue_op_type;

   typedef struct packed {
      smpq_status_type          status;
      logic                     hit;
      logic [FIELD_W-1:0]       tag;
      logic [FIELD_W-1:0]       prio;
      logic [OCC_W-1:0]         occ;
   } queue_result_type;

   typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIXED, RUN_NOISE} run_kind_type;
   typedef enum {PRIO_TIES, PRIO_SPREAD, PRIO_EXTREMES} prio_kind_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser  = MODE_INSERT;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   queue_op_type     pending_ops[$];
   queue_result_type expected_results[$];

   // shadow copy of the sorted queue, slot 0 is the head
   logic [PRIORITY_BITS-1:0] shadow_prio [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]      shadow_tag  [QUEUE_DEPTH];
   int                       shadow_count = 0;

   int ops_total    = 0;
   int ops_accepted = 0;
   int results_seen = 0;
   int error_count  = 0;
   int cycle_count  = 0;
   int send_gap     = 0;
   int recv_gap     = 0;
   bit send_calm    = 1'b0;
   bit recv_calm    = 1'b0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   stable_max_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one request to the shadow queue and work out its result
   function automatic queue_result_type apply_queue_op(queue_op_type op);
      queue_result_type res;
      int               pos;
      int               i;
      res.status = STATUS_OK;
      res.hit    = 1'b0;
      res.tag    = '0;
      res.prio   = '0;
      if (op.mode == MODE_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            // new entry goes behind every entry of equal or higher priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] >= op.prio) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_prio[i] = shadow_prio[i-1];
               shadow_tag[i]  = shadow_tag[i-1];
            end
            shadow_prio[pos] = op.prio;
            shadow_tag[pos]  = op.tag;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.hit  = 1'b1;
            res.tag  = shadow_tag[0];
            res.prio = shadow_prio[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_prio[i-1] = shadow_prio[i];
               shadow_tag[i-1]  = shadow_tag[i];
            end
            shadow_count--;
         end
      end
      res.occ = OCC_W'(shadow_count);
      return res;
   endfunction

   task automatic add_op(input logic mode, input logic [TAG_BITS-1:0] tag,
                         input logic [PRIORITY_BITS-1:0] prio);
      queue_op_type op;
      op.mode = mode;
      op.tag  = tag;
      op.prio = prio;
      pending_ops.push_back(op);
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, field, got, want);
      error_count++;
   endtask

   function automatic logic [PRIORITY_BITS-1:0] pick_prio(prio_kind_type kind);
      logic [PRIORITY_BITS-1:0] p;
      case (kind)
         PRIO_TIES:   p = PRIORITY_BITS'($urandom_range(0, 3));
         PRIO_SPREAD: p = PRIORITY_BITS'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0:       p = '0;
               1:       p = PRIORITY_BITS'(1);
               2:       p = '1 - PRIORITY_BITS'(1);
               default: p = '1;
            endcase
         end
      endcase
      return p;
   endfunction

   // stimulus build, reset and end of run
   initial begin
      int            i;
      int            run_len;
      int            cut;
      run_kind_type  run_kind;
      prio_kind_type prio_kind;
      logic          mode;

      // directed: consume on empty, extremes, ties, fill to full, drop, drain a few
      add_op(MODE_CONSUME, 16'hFFFF, 16'hFFFF);
      add_op(MODE_INSERT, 16'h0000, 16'h0000);
      add_op(MODE_INSERT, 16'hFFFF, 16'hFFFF);
      add_op(MODE_INSERT, 16'h0001, 16'h8000);
      add_op(MODE_INSERT, 16'h0002, 16'h8000);
      add_op(MODE_INSERT, 16'h0003, 16'h8000);
      add_op(MODE_INSERT, 16'h0004, 16'h0000);
      add_op(MODE_INSERT, 16'h0005, 16'hFFFF);
      add_op(MODE_INSERT, 16'h0006, 16'h0001);
      add_op(MODE_INSERT, 16'h0007, 16'h7FFF);
      for (i = 0; i < 7; i++) begin
         case (i % 3)
            0:       add_op(MODE_INSERT, TAG_BITS'(16'h0010 + i), 16'h8000);
            1:       add_op(MODE_INSERT, TAG_BITS'(16'h0010 + i), 16'h0001);
            default: add_op(MODE_INSERT, TAG_BITS'(16'h0010 + i), 16'hFFFF);
         endcase
      end
      add_op(MODE_INSERT, 16'hAAAA, 16'hFFFF);
      for (i = 0; i < 4; i++) add_op(MODE_CONSUME, 16'h5555, 16'h0000);

      // random runs that push the queue towards full or empty, with some noise
      while (pending_ops.size() < ITEM_COUNT) begin
         run_len   = $urandom_range(8, 48);
         run_kind  = run_kind_type'($urandom_range(0, 3));
         prio_kind = prio_kind_type'($urandom_range(0, 2));
         case (run_kind)
            RUN_FILL:  cut = 80;
            RUN_DRAIN: cut = 20;
            default:   cut = 50;
         endcase
         for (i = 0; i < run_len; i++) begin
            mode = ($urandom_range(0, 99) < cut) ? MODE_INSERT : MODE_CONSUME;
            if (run_kind == RUN_NOISE)
               add_op(mode, TAG_BITS'($urandom), PRIORITY_BITS'($urandom));
            else
               add_op(mode, TAG_BITS'($urandom), pick_prio(prio_kind));
         end
      end
      ops_total = pending_ops.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (ops_accepted < ops_total) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("stable_max_priority_queue regression: pass");
      else
         $display("stable_max_priority_queue regression: fail");
      $finish;
   end

   // request driver: one transfer per request, random gaps between them
   always @(posedge clock) begin : drive_proc
      queue_op_type op;
      bit           offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            op.mode = req_tuser;
            op.tag  = req_tdata[15:0];
            op.prio = req_tdata[31:16];
            expected_results.push_back(apply_queue_op(op));
            ops_accepted++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_ops.size() > 0) begin
               if (!send_calm && ops_accepted < ops_total - CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(0, 15);
               end else begin
                  op = pending_ops.pop_front();
                  req_tuser <= op.mode;
                  req_tdata <= {op.prio, op.tag};
                  offer = 1'b1;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
         req_tvalid <= offer;
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin : watch_proc
      queue_result_type want;
      bit               ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer", 64'({rsp_tuser, rsp_tdata}), '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser[1:0] !== want.status)
                  report_mismatch("status", 64'(rsp_tuser[1:0]), 64'(want.status));
               if (rsp_tuser[2] !== want.hit)
                  report_mismatch("out_valid", 64'(rsp_tuser[2]), 64'(want.hit));
               if (rsp_tdata[15:0] !== want.tag)
                  report_mismatch("out_tag", 64'(rsp_tdata[15:0]), 64'(want.tag));
               if (rsp_tdata[31:16] !== want.prio)
                  report_mismatch("out_priority", 64'(rsp_tdata[31:16]), 64'(want.prio));
               if (rsp_tdata[36:32] !== want.occ)
                  report_mismatch("occupancy", 64'(rsp_tdata[36:32]), 64'(want.occ));
               if (rsp_tdata[39:37] !== 3'b000)
                  report_mismatch("padding", 64'(rsp_tdata[39:37]), '0);
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            ready = 1'b0;
         end else if (!recv_calm && ops_accepted < ops_total - CALM_TAIL &&
                      $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 15);
            ready = 1'b0;
         end else begin
            ready = 1'b1;
         end
         if (hold_left > 0) ready = 1'b0;
         if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
         rsp_tready <= ready;
      end
   end

   // one long hold-off on the result side so the output register fills and the block stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stable_max_priority_queue regression: fail");
         $finish;
      end
   end

endmodule

### stable_max_priority_queue.f
+incdir+design
design/smpq_pkg.sv
design/stable_max_priority_queue.sv
tb/tb.sv
